### hdl/bloom_filter_insert_query_macros.svh
// Assertion helpers for the filter block.
`ifndef BLOOM_FILTER_INSERT_QUERY_MACROS_SVH
`define BLOOM_FILTER_INSERT_QUERY_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BFIQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BFIQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/bfiq_pkg.sv
package bfiq_pkg;

   localparam int INDEX_BITS    = 14;
   localparam int NUM_SUBHASHES = 5;
   localparam int HASH_BITS     = 256;
   localparam int WORD_BITS     = 64;

   // filter is 2^INDEX_BITS bits held as bytes
   localparam int ADDR_BITS   = INDEX_BITS - 3;
   localparam int STORE_DEPTH = 1 << ADDR_BITS;
   localparam int SUB_BITS    = (NUM_SUBHASHES > 1) ? $clog2(NUM_SUBHASHES) : 1;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic                 operation;
      logic [WORD_BITS-1:0] hash_word0;
      logic [WORD_BITS-1:0] hash_word1;
      logic [WORD_BITS-1:0] hash_word2;
      logic [WORD_BITS-1:0] hash_word3;
   } req_type;

   typedef struct packed {
      logic is_member;
      logic was_query;
   } rsp_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
      logic [7:0]           data;
   } mem_wr_type;

endpackage

### hdl/bfiq_store.sv
module bfiq_store (
   input  logic                          clock,
   input  bfiq_pkg::mem_wr_type          wr,
   input  logic [bfiq_pkg::ADDR_BITS-1:0] rd_addr,
   output logic [7:0]                    rd_data
);

   logic [7:0] mem [bfiq_pkg::STORE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/bloom_filter_insert_query.sv
// Each request walks its slices in turn, a read state then an update state per slice,
// then a finish state that loads the registered response once that register is free;
// a query that meets a clear bit finishes early and skips its remaining slices. A new
// request is taken only when the previous one is done; each slice needs a read and a
// compare/write-back through the filter memory's read and write ports. Reset: synchronous;
// the filter's STORE_DEPTH bytes (2048 by default) are then swept to zero, with req_ready low until the sweep is done.
`include "bloom_filter_insert_query_macros.svh"

module bloom_filter_insert_query (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfiq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfiq_pkg::rsp_type rsp_payload
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_UPD   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [bfiq_pkg::ADDR_BITS-1:0] clr_ff, clr_in;
   logic [bfiq_pkg::SUB_BITS-1:0]  sub_ff, sub_in;
   logic [bfiq_pkg::HASH_BITS-1:0] hash_ff, hash_in;
   logic                           op_ff, op_in;
   logic                           member_ff, member_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   bfiq_pkg::rsp_type              rsp_ff, rsp_in;

   bfiq_pkg::mem_wr_type           mem_wr;
   logic [bfiq_pkg::ADDR_BITS-1:0] rd_addr;
   logic [7:0]                     rd_data;
   logic [2:0]                     bit_sel;
   logic [7:0]                     bit_mask;
   logic                           last_sub;
   logic                           rsp_free;

   bfiq_store u_store (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // current slice sits in the low bits of the hash shifter
   assign rd_addr  = hash_ff[bfiq_pkg::INDEX_BITS-1:3];
   assign bit_sel  = hash_ff[2:0];
   assign bit_mask = 8'b1 << bit_sel;
   assign last_sub = (sub_ff == bfiq_pkg::SUB_BITS'(bfiq_pkg::NUM_SUBHASHES - 1));
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      sub_in       = sub_ff;
      hash_in      = hash_ff;
      op_in        = op_ff;
      member_in    = member_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_wr.en    = 1'b0;
      mem_wr.addr  = rd_addr;
      mem_wr.data  = rd_data | bit_mask;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = clr_ff;
            mem_wr.data = 8'h00;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == {bfiq_pkg::ADDR_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               hash_in   = {req_payload.hash_word3, req_payload.hash_word2,
                            req_payload.hash_word1, req_payload.hash_word0};
               op_in     = req_payload.operation;
               member_in = 1'b1;
               sub_in    = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (op_ff == bfiq_pkg::OP_INSERT) begin
               mem_wr.en = 1'b1;
            end
            hash_in = hash_ff >> bfiq_pkg::INDEX_BITS;
            sub_in  = sub_ff + 1'b1;
            if (op_ff == bfiq_pkg::OP_QUERY && !rd_data[bit_sel]) begin
               // first clear bit ends the query
               member_in = 1'b0;
               state_in  = ST_FIN;
            end else if (last_sub) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.is_member = (op_ff == bfiq_pkg::OP_QUERY) && member_ff;
               rsp_in.was_query = op_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sub_ff    <= sub_in;
      hash_ff   <= hash_in;
      op_ff     <= op_in;
      member_ff <= member_in;
      rsp_ff    <= rsp_in;
   end

   `BFIQ_ASSERT_NEXT(a_req_starts_read, clock, reset, req_valid && req_ready, state_ff == ST_READ, "req transfer did not start a slice read")
   `BFIQ_ASSERT_NOW(a_write_source, clock, reset, mem_wr.en, state_ff == ST_CLEAR || (state_ff == ST_UPD && op_ff == bfiq_pkg::OP_INSERT), "filter written outside clear or insert")
   `BFIQ_ASSERT_NEXT(a_fin_loads_rsp, clock, reset, state_ff == ST_FIN && rsp_free, rsp_valid_ff && rsp_ff.was_query == op_ff, "finished item not loaded into response register")
   `BFIQ_ASSERT_NOW(a_insert_not_member, clock, reset, rsp_valid_ff && !rsp_ff.was_query, !rsp_ff.is_member, "insert response reports membership")

endmodule
